@@ hw/rtl/pvsc_pkg.sv @@
// Shared constants for the polygon vertex spacing check.
// No dependencies; compiled first.
`default_nettype none

package pvsc_pkg;

    // Parameter defaults
    localparam int DEF_MAX_POINTS   = 256;
    localparam int DEF_MAX_CONTOURS = 8;
    localparam int DEF_COORD_BITS   = 24;

    // Fixed field widths
    localparam int DIST_BITS    = 23;
    localparam int GAP_BITS     = 2 * DIST_BITS;
    localparam int CONTOUR_BITS = 4;

endpackage

`default_nettype wire

@@ hw/rtl/pvsc_vertex_if.sv @@
// Vertex input channel: valid/ready handshake plus one vertex beat.
// Depends on pvsc_pkg.
`default_nettype none

interface pvsc_vertex_if import pvsc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         contour_end;
    logic                         set_end;

    modport source (output valid, vertex_x, vertex_y, contour_end, set_end, input ready);
    modport sink   (input valid, vertex_x, vertex_y, contour_end, set_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pvsc_result_if.sv @@
// Result output channel: valid/ready handshake plus one result beat.
// Depends on pvsc_pkg.
`default_nettype none

interface pvsc_result_if import pvsc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [CONTOUR_BITS-1:0]      first_contour;
    logic [CONTOUR_BITS-1:0]      second_contour;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic [GAP_BITS-1:0]          squared_gap;
    logic                         overflow;
    logic                         last;

    modport source (
        output valid, found, first_contour, second_contour, first_x, first_y,
               second_x, second_y, squared_gap, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, found, first_contour, second_contour, first_x, first_y,
               second_x, second_y, squared_gap, overflow, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/pvsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pvsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/polygon_vertex_spacing_check.sv @@
// Polygon vertex spacing check top level: vertex load, pairwise closest-pair
// search over stored contours, result buffering.
// Depends on pvsc_pkg, pvsc_vertex_if, pvsc_result_if, pvsc_ram.
//
//   channel    dir   beat                                         handshake
//   i_vertex   in    vertex_x, vertex_y, contour_end, set_end      valid/ready
//   o_result   out   found, contours, vertices, squared_gap, ...   valid/ready
//   i_cfg_*    in    max_distance                                  write enable
//
// Loading takes one vertex per cycle; each vertex that fits is written to the point RAM.
// After a set_end beat the search runs with the vertex input held off. Per
// contour pair it reads the contour bounds, then for each outer vertex streams
// the inner contour's vertices through the single point RAM read port and
// drains the distance pipeline; the run closes with a final result beat.
// Reset clears counts, flags and the limit; the RAMs are not cleared.
// A result waits in a one-deep pending slot and the output register, so the
// search stalls only when both are full.
`default_nettype none

module polygon_vertex_spacing_check import pvsc_pkg::*; #(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_CONTOURS = DEF_MAX_CONTOURS,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    pvsc_vertex_if.sink         i_vertex,
    pvsc_result_if.source       o_result,
    input  wire                 i_cfg_we,
    input  wire [DIST_BITS-1:0] i_cfg_wdata
);

    localparam int PTR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CIX_W  = $clog2(MAX_CONTOURS);
    localparam int CCNT_W = $clog2(MAX_CONTOURS + 1);
    localparam int CMP_W  = (COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS;
    localparam int CNUM_W = (CCNT_W + 1 > CONTOUR_BITS) ? CCNT_W + 1 : CONTOUR_BITS;
    localparam int PT_W   = 2 * COORD_BITS;

    // State codes
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_CI    = 4'd1;
    localparam logic [3:0] ST_CIW   = 4'd2;
    localparam logic [3:0] ST_CJ    = 4'd3;
    localparam logic [3:0] ST_CJW   = 4'd4;
    localparam logic [3:0] ST_PA    = 4'd5;
    localparam logic [3:0] ST_PAW   = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_DRAIN = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;
    localparam logic [3:0] ST_END   = 4'd10;

    typedef struct packed {
        logic                         found;
        logic [CONTOUR_BITS-1:0]      first_contour;
        logic [CONTOUR_BITS-1:0]      second_contour;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic [GAP_BITS-1:0]          squared_gap;
        logic                         overflow;
        logic                         last;
    } t_result;

    // Control registers
    logic [3:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_pc;
    logic [CNT_W-1:0]     r_open_start;
    logic [CCNT_W-1:0]    r_cc;
    logic                 r_ovf;
    logic [DIST_BITS-1:0] r_maxd;
    logic [GAP_BITS-1:0]  r_dsq;

    // Search registers
    logic [CCNT_W-1:0]    r_i, r_j;
    logic [CNT_W-1:0]     r_a_start, r_a_end, r_b_start, r_b_end;
    logic [CNT_W-1:0]     r_a, r_b;
    logic signed [COORD_BITS-1:0] r_ax, r_ay;
    logic                 r_hit;
    logic [GAP_BITS-1:0]  r_best;
    logic signed [COORD_BITS-1:0] r_bfx, r_bfy, r_bsx, r_bsy;

    // Distance pipeline
    logic                 r_v0, r_v1, r_v2;
    logic [COORD_BITS-1:0] r_s1_dx, r_s1_dy;
    logic signed [COORD_BITS-1:0] r_s1_bx, r_s1_by;
    logic                 r_s2_ok;
    logic [GAP_BITS-1:0]  r_s2_sqx, r_s2_sqy;
    logic signed [COORD_BITS-1:0] r_s2_bx, r_s2_by;

    // Result buffering
    logic                 r_pend_v, r_out_v;
    t_result              r_pend, r_out;

    // RAM ports
    logic                 w_pt_we;
    logic [PTR_W-1:0]     w_pt_raddr;
    logic [PT_W-1:0]      w_pt_rdata;
    logic                 w_ce_we;
    logic [CIX_W-1:0]     w_ce_raddr;
    logic [CNT_W-1:0]     w_ce_rdata;

    // Load datapath
    logic                 w_in_acc;
    logic                 w_store;
    logic [CNT_W-1:0]     w_pc_new;
    logic                 w_close;
    logic [CCNT_W-1:0]    w_cc_new;

    // Pipeline combinational terms
    logic signed [COORD_BITS-1:0] w_bx, w_by;
    logic signed [COORD_BITS:0]   w_dx_s, w_dy_s;
    logic [COORD_BITS:0]          w_dx_m, w_dy_m;
    logic [CMP_W-1:0]             w_dx_e, w_dy_e;
    logic [DIST_BITS-1:0]         w_opx, w_opy;
    logic [GAP_BITS:0]            w_sq;
    logic                         w_better;

    // Pair bookkeeping
    logic [CNUM_W-1:0]    w_fc_full, w_sc_full;
    logic                 w_more_j, w_more_i, w_more_a, w_pipe_idle;
    t_result              w_new_res, w_none_res, w_last_res;

    assign w_in_acc = i_vertex.valid && i_vertex.ready;
    assign i_vertex.ready = (r_state == ST_LOAD);

    // Capacity checks and contour closing on a load beat
    always_comb begin
        w_store  = (r_cc < CCNT_W'(MAX_CONTOURS)) && (r_pc < CNT_W'(MAX_POINTS));
        w_pc_new = r_pc + CNT_W'(w_store);
        w_close  = (i_vertex.contour_end || i_vertex.set_end)
                   && (r_cc < CCNT_W'(MAX_CONTOURS)) && (w_pc_new > r_open_start);
        w_cc_new = r_cc + CCNT_W'(w_close);
    end

    assign w_pt_we    = w_in_acc && w_store;
    assign w_ce_we    = w_in_acc && w_close;
    assign w_pt_raddr = (r_state == ST_PA) ? r_a[PTR_W-1:0] : r_b[PTR_W-1:0];
    assign w_ce_raddr = (r_state == ST_CI) ? r_i[CIX_W-1:0] : r_j[CIX_W-1:0];

    pvsc_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_pc[PTR_W-1:0]),
        .i_wdata ({i_vertex.vertex_x, i_vertex.vertex_y}),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rdata)
    );

    pvsc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CONTOURS)
    ) u_contour_ram (
        .i_clk   (i_clk),
        .i_we    (w_ce_we),
        .i_waddr (r_cc[CIX_W-1:0]),
        .i_wdata (w_pc_new),
        .i_raddr (w_ce_raddr),
        .o_rdata (w_ce_rdata)
    );

    // Stage one: absolute coordinate differences
    always_comb begin
        w_bx   = w_pt_rdata[PT_W-1:COORD_BITS];
        w_by   = w_pt_rdata[COORD_BITS-1:0];
        w_dx_s = (COORD_BITS+1)'(r_ax) - (COORD_BITS+1)'(w_bx);
        w_dy_s = (COORD_BITS+1)'(r_ay) - (COORD_BITS+1)'(w_by);
        w_dx_m = w_dx_s[COORD_BITS] ? (~w_dx_s + 1'b1) : w_dx_s;
        w_dy_m = w_dy_s[COORD_BITS] ? (~w_dy_s + 1'b1) : w_dy_s;
    end

    // Stage two operands: limit check and narrow square inputs
    always_comb begin
        w_dx_e = CMP_W'(r_s1_dx);
        w_dy_e = CMP_W'(r_s1_dy);
        w_opx  = w_dx_e[DIST_BITS-1:0];
        w_opy  = w_dy_e[DIST_BITS-1:0];
    end

    // Stage three: sum and compare against the running best
    always_comb begin
        w_sq     = (GAP_BITS+1)'(r_s2_sqx) + (GAP_BITS+1)'(r_s2_sqy);
        w_better = r_v2 && r_s2_ok && (w_sq <= (GAP_BITS+1)'(r_best));
    end

    // Loop bounds and result assembly
    always_comb begin
        w_pipe_idle = !r_v0 && !r_v1 && !r_v2;
        w_more_a    = (r_a + CNT_W'(1)) < r_a_end;
        w_more_j    = ((CCNT_W+1)'(r_j) + (CCNT_W+1)'(1)) < (CCNT_W+1)'(r_cc);
        w_more_i    = ((CCNT_W+1)'(r_i) + (CCNT_W+1)'(2)) < (CCNT_W+1)'(r_cc);
        w_fc_full   = CNUM_W'(r_i) + CNUM_W'(1);
        w_sc_full   = CNUM_W'(r_j) + CNUM_W'(1);

        w_new_res.found          = 1'b1;
        w_new_res.first_contour  = w_fc_full[CONTOUR_BITS-1:0];
        w_new_res.second_contour = w_sc_full[CONTOUR_BITS-1:0];
        w_new_res.first_x        = r_bfx;
        w_new_res.first_y        = r_bfy;
        w_new_res.second_x       = r_bsx;
        w_new_res.second_y       = r_bsy;
        w_new_res.squared_gap    = r_best;
        w_new_res.overflow       = r_ovf;
        w_new_res.last           = 1'b0;

        w_none_res          = '0;
        w_none_res.overflow = r_ovf;
        w_none_res.last     = 1'b1;

        // Pending pair marked as the final beat of the run
        w_last_res      = r_pend;
        w_last_res.last = 1'b1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_vertex.set_end) begin
                    n_state = (w_cc_new >= CCNT_W'(2)) ? ST_CI : ST_END;
                end
            end
            ST_CI:    n_state = ST_CIW;
            ST_CIW:   n_state = ST_CJ;
            ST_CJ:    n_state = ST_CJW;
            ST_CJW:   n_state = ST_PA;
            ST_PA:    n_state = ST_PAW;
            ST_PAW:   n_state = ST_SCAN;
            ST_SCAN: begin
                if ((r_b + CNT_W'(1)) == r_b_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_pipe_idle) begin
                    n_state = w_more_a ? ST_PA : ST_FIN;
                end
            end
            ST_FIN: begin
                if (!(r_hit && r_pend_v && r_out_v)) begin
                    if (w_more_j) begin
                        n_state = ST_CJ;
                    end else if (w_more_i) begin
                        n_state = ST_CI;
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (!r_out_v) begin
                    n_state = ST_LOAD;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
    end

    // Control state: counts, flags, limit, buffer valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_pc         <= '0;
            r_open_start <= '0;
            r_cc         <= '0;
            r_ovf        <= 1'b0;
            r_maxd       <= '0;
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v0    <= (r_state == ST_SCAN);
            r_v1    <= r_v0;
            r_v2    <= r_v1;

            if (i_cfg_we) begin
                r_maxd <= i_cfg_wdata;
            end

            // Load beat: store vertex, close contour, flag drops
            if (w_in_acc) begin
                r_pc <= w_pc_new;
                r_cc <= w_cc_new;
                if (!w_store) begin
                    r_ovf <= 1'b1;
                end
                if (w_close) begin
                    r_open_start <= w_pc_new;
                end
            end

            // Drop the output beat once taken
            if (o_result.valid && o_result.ready) begin
                r_out_v <= 1'b0;
            end

            // Push a finished pair; release the older pending one
            if (r_state == ST_FIN && r_hit && !(r_pend_v && r_out_v)) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
            end

            // Close the run with the final beat and clear the set
            if (r_state == ST_END && !r_out_v) begin
                r_out_v      <= 1'b1;
                r_pend_v     <= 1'b0;
                r_pc         <= '0;
                r_cc         <= '0;
                r_open_start <= '0;
                r_ovf        <= 1'b0;
            end
        end
    end

    // Search datapath
    always_ff @(posedge i_clk) begin
        r_dsq <= r_maxd * r_maxd;

        // Stage one
        r_s1_dx <= w_dx_m[COORD_BITS-1:0];
        r_s1_dy <= w_dy_m[COORD_BITS-1:0];
        r_s1_bx <= w_bx;
        r_s1_by <= w_by;

        // Stage two
        r_s2_ok  <= !(w_dx_e > CMP_W'(r_maxd)) && !(w_dy_e > CMP_W'(r_maxd));
        r_s2_sqx <= w_opx * w_opx;
        r_s2_sqy <= w_opy * w_opy;
        r_s2_bx  <= r_s1_bx;
        r_s2_by  <= r_s1_by;

        // Stage three: keep the closest pair, later pair on a tie
        if (w_better) begin
            r_best <= w_sq[GAP_BITS-1:0];
            r_hit  <= 1'b1;
            r_bfx  <= r_ax;
            r_bfy  <= r_ay;
            r_bsx  <= r_s2_bx;
            r_bsy  <= r_s2_by;
        end

        unique case (r_state)
            ST_LOAD: begin
                r_i       <= '0;
                r_j       <= CCNT_W'(1);
                r_a_start <= '0;
            end
            ST_CIW: begin
                r_a_end   <= w_ce_rdata;
                r_b_start <= w_ce_rdata;
            end
            ST_CJW: begin
                r_b_end <= w_ce_rdata;
                r_a     <= r_a_start;
                r_best  <= r_dsq;
                r_hit   <= 1'b0;
            end
            ST_PAW: begin
                r_ax <= w_pt_rdata[PT_W-1:COORD_BITS];
                r_ay <= w_pt_rdata[COORD_BITS-1:0];
                r_b  <= r_b_start;
            end
            ST_SCAN: begin
                r_b <= r_b + CNT_W'(1);
            end
            ST_DRAIN: begin
                if (w_pipe_idle && w_more_a) begin
                    r_a <= r_a + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (!(r_hit && r_pend_v && r_out_v)) begin
                    if (r_hit) begin
                        r_pend <= w_new_res;
                        if (r_pend_v) begin
                            r_out <= r_pend;
                        end
                    end
                    if (w_more_j) begin
                        r_b_start <= r_b_end;
                        r_j       <= r_j + CCNT_W'(1);
                    end else if (w_more_i) begin
                        r_a_start <= r_a_end;
                        r_i       <= r_i + CCNT_W'(1);
                        r_j       <= r_i + CCNT_W'(2);
                    end
                end
            end
            ST_END: begin
                if (!r_out_v) begin
                    if (r_pend_v) begin
                        r_out <= w_last_res;
                    end else begin
                        r_out <= w_none_res;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output beat
    assign o_result.valid          = r_out_v;
    assign o_result.found          = r_out.found;
    assign o_result.first_contour  = r_out.first_contour;
    assign o_result.second_contour = r_out.second_contour;
    assign o_result.first_x        = r_out.first_x;
    assign o_result.first_y        = r_out.first_y;
    assign o_result.second_x       = r_out.second_x;
    assign o_result.second_y       = r_out.second_y;
    assign o_result.squared_gap    = r_out.squared_gap;
    assign o_result.overflow       = r_out.overflow;
    assign o_result.last           = r_out.last;

`ifndef ASSERT_OFF
    // No distance work in flight while vertices load
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vertex.ready |-> (!r_v0 && !r_v1 && !r_v2))
        else $error("distance pipeline active during load");

    // Point count stays within the store
    a_pc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    // Leaving the run always presents a final beat
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && !r_out_v) |=> (r_out_v && r_out.last))
        else $error("run closed without a last beat");

    // A kept pair never exceeds the squared limit
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit && (r_state == ST_FIN)) |-> (r_best <= r_dsq))
        else $error("best gap above squared limit");

    // A pending result only exists mid-run
    a_pend_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state != ST_LOAD))
        else $error("pending result left after run");
`endif

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for polygon_vertex_spacing_check: streams vertex sets,
// predicts the closest vertex pair of each contour pair and checks every result beat.
// Depends on pvsc_pkg, pvsc_vertex_if, pvsc_result_if and the RTL top level.

import pvsc_pkg::*;

typedef struct {
    logic signed [DEF_COORD_BITS-1:0] x;
    logic signed [DEF_COORD_BITS-1:0] y;
    logic                             contour_end;
    logic                             set_end;
} t_vertex_beat;

typedef struct {
    logic                      found;
    logic [CONTOUR_BITS-1:0]   first_contour;
    logic [CONTOUR_BITS-1:0]   second_contour;
    logic [DEF_COORD_BITS-1:0] first_x;
    logic [DEF_COORD_BITS-1:0] first_y;
    logic [DEF_COORD_BITS-1:0] second_x;
    logic [DEF_COORD_BITS-1:0] second_y;
    logic [GAP_BITS-1:0]       squared_gap;
    logic                      overflow;
    logic                      last;
} t_spacing_result;

// Tracks the stored contours and the limit, and holds the pair reports still due
class spacing_scoreboard;
    logic signed [DEF_COORD_BITS-1:0] pt_x[DEF_MAX_POINTS];
    logic signed [DEF_COORD_BITS-1:0] pt_y[DEF_MAX_POINTS];
    int unsigned          contour_stop[DEF_MAX_CONTOURS];
    int unsigned          n_points = 0;
    int unsigned          n_contours = 0;
    bit                   dropped = 1'b0;
    logic [DIST_BITS-1:0] limit = '0;
    t_spacing_result      pending_pairs[$];
    int unsigned          errors = 0;
    int unsigned          checked = 0;
    int unsigned          close_pairs = 0;
    int unsigned          runs = 0;
    int unsigned          overflow_runs = 0;

    function void set_limit(logic [DIST_BITS-1:0] value);
        limit = value;
    endfunction

    function int unsigned contour_first(int unsigned c);
        return (c == 0) ? 0 : contour_stop[c-1];
    endfunction

    function longint unsigned axis_gap(logic signed [DEF_COORD_BITS-1:0] p,
                                       logic signed [DEF_COORD_BITS-1:0] q);
        longint d;
        d = longint'(p) - longint'(q);
        return (d < 0) ? longint'(-d) : d;
    endfunction

    // Close the open contour unless it holds no stored vertex or the table is full
    function void close_contour();
        if (n_contours < DEF_MAX_CONTOURS && n_points > contour_first(n_contours)) begin
            contour_stop[n_contours] = n_points;
            n_contours++;
        end
    endfunction

    // Scan every contour pair, outer vertex on the earlier contour; later ties win
    function void find_closest_pairs();
        longint unsigned lim, best, dx, dy, cheb, sq;
        int unsigned     a_best, b_best, n;
        bit              hit;
        t_spacing_result r;
        n = 0;
        lim = 64'(limit);
        runs++;
        if (dropped) overflow_runs++;
        for (int unsigned i = 0; i < n_contours; i++) begin
            for (int unsigned j = i + 1; j < n_contours; j++) begin
                hit = 1'b0;
                best = lim * lim;
                a_best = 0;
                b_best = 0;
                for (int unsigned a = contour_first(i); a < contour_stop[i]; a++) begin
                    for (int unsigned b = contour_first(j); b < contour_stop[j]; b++) begin
                        dx = axis_gap(pt_x[a], pt_x[b]);
                        dy = axis_gap(pt_y[a], pt_y[b]);
                        cheb = (dx > dy) ? dx : dy;
                        if (cheb <= lim) begin
                            sq = dx * dx + dy * dy;
                            if (sq <= best) begin
                                best = sq;
                                a_best = a;
                                b_best = b;
                                hit = 1'b1;
                            end
                        end
                    end
                end
                if (hit) begin
                    r.found = 1'b1;
                    r.first_contour = CONTOUR_BITS'(i + 1);
                    r.second_contour = CONTOUR_BITS'(j + 1);
                    r.first_x = pt_x[a_best];
                    r.first_y = pt_y[a_best];
                    r.second_x = pt_x[b_best];
                    r.second_y = pt_y[b_best];
                    r.squared_gap = GAP_BITS'(best);
                    r.overflow = dropped;
                    r.last = 1'b0;
                    pending_pairs = {pending_pairs, r};
                    n++;
                end
            end
        end
        // No close pair anywhere: one not-found beat
        if (n == 0) begin
            r = '{default: '0};
            r.overflow = dropped;
            pending_pairs = {pending_pairs, r};
        end
        pending_pairs[pending_pairs.size()-1].last = 1'b1;
    endfunction

    // Store an accepted vertex beat; a set end runs the search and starts over
    function void note_vertex(t_vertex_beat v);
        if (n_contours >= DEF_MAX_CONTOURS || n_points >= DEF_MAX_POINTS) begin
            dropped = 1'b1;
        end else begin
            pt_x[n_points] = v.x;
            pt_y[n_points] = v.y;
            n_points++;
        end
        if (v.contour_end || v.set_end) close_contour();
        if (v.set_end) begin
            find_closest_pairs();
            n_points = 0;
            n_contours = 0;
            dropped = 1'b0;
        end
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare a result beat against the oldest pair report still due
    function void check_result(t_spacing_result got);
        t_spacing_result want;
        if (pending_pairs.size() == 0) begin
            $error("result beat with no report due (found=%0b)", got.found);
            errors++;
            return;
        end
        want = pending_pairs.pop_front();
        match_field("found", 64'(want.found), 64'(got.found));
        match_field("first_contour", 64'(want.first_contour), 64'(got.first_contour));
        match_field("second_contour", 64'(want.second_contour), 64'(got.second_contour));
        match_field("first_x", 64'(want.first_x), 64'(got.first_x));
        match_field("first_y", 64'(want.first_y), 64'(got.first_y));
        match_field("second_x", 64'(want.second_x), 64'(got.second_x));
        match_field("second_y", 64'(want.second_y), 64'(got.second_y));
        match_field("squared_gap", 64'(want.squared_gap), 64'(got.squared_gap));
        match_field("overflow", 64'(want.overflow), 64'(got.overflow));
        match_field("last", 64'(want.last), 64'(got.last));
        checked++;
        if (want.found) close_pairs++;
    endfunction
endclass

module testbench;

    localparam int RANDOM_ITEMS = 96;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 600;
    // Slowest run is far below this: at most 152 vertices, their searches, one long
    // ready hold and both sides idling about a third of the time.
    localparam int LIMIT_CYCLES = 500_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [DIST_BITS-1:0] i_cfg_wdata;

    pvsc_vertex_if vertex_ch ();
    pvsc_result_if result_ch ();

    polygon_vertex_spacing_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vertex    (vertex_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    spacing_scoreboard sb;
    t_spacing_result   seen_beat;
    bit                steady = 1'b0;
    bit                hold_rx = 1'b0;
    int unsigned       hold_left = 0;
    int unsigned       cycle_count = 0;
    int unsigned       items_sent = 0;
    int unsigned       random_items = 0;
    int unsigned       set_index = 0;

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** polygon_vertex_spacing_check: FAILED **");
            $finish;
        end
    end

    // Capture each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            seen_beat.found = result_ch.found;
            seen_beat.first_contour = result_ch.first_contour;
            seen_beat.second_contour = result_ch.second_contour;
            seen_beat.first_x = result_ch.first_x;
            seen_beat.first_y = result_ch.first_y;
            seen_beat.second_x = result_ch.second_x;
            seen_beat.second_y = result_ch.second_y;
            seen_beat.squared_gap = result_ch.squared_gap;
            seen_beat.overflow = result_ch.overflow;
            seen_beat.last = result_ch.last;
            sb.check_result(seen_beat);
        end
    end

    // Drive result ready: random stalls, a long hold on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_rx) begin
                hold_rx = 1'b0;
                hold_left = LONG_HOLD - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= steady || ($urandom_range(99) >= 32);
            end
        end
    end

    function automatic t_vertex_beat beat_of(logic [DEF_COORD_BITS-1:0] x,
                                             logic [DEF_COORD_BITS-1:0] y,
                                             logic cend, logic send);
        t_vertex_beat v;
        v.x = x;
        v.y = y;
        v.contour_end = cend;
        v.set_end = send;
        return v;
    endfunction

    // Offer one vertex beat after random idle cycles; return at the next falling edge
    task automatic send_vertex(input t_vertex_beat v);
        while (!steady && $urandom_range(99) < 32) begin
            vertex_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        vertex_ch.valid <= 1'b1;
        vertex_ch.vertex_x <= v.x;
        vertex_ch.vertex_y <= v.y;
        vertex_ch.contour_end <= v.contour_end;
        vertex_ch.set_end <= v.set_end;
        do @(posedge i_clk); while (vertex_ch.ready !== 1'b1);
        sb.note_vertex(v);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drain all reports, let the search wind down, then write the limit
    task automatic write_limit(input logic [DIST_BITS-1:0] value);
        vertex_ch.valid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    // One random set clustered around a center, spread scaled to the limit
    task automatic random_set();
        int unsigned          n_cont, n_vert;
        longint               spread, off_x, off_y;
        logic [DEF_COORD_BITS-1:0] cx, cy;
        t_vertex_beat         v;
        n_cont = ($urandom_range(9) == 0) ? 9 : $urandom_range(6, 1);
        spread = (sb.limit < 4) ? 4 : longint'(sb.limit) + longint'(sb.limit) / 2;
        if (spread > (1 << 23)) spread = 1 << 23;
        cx = DEF_COORD_BITS'($urandom);
        cy = DEF_COORD_BITS'($urandom);
        for (int unsigned c = 0; c < n_cont; c++) begin
            n_vert = $urandom_range(4, 1);
            for (int unsigned k = 0; k < n_vert; k++) begin
                if ($urandom_range(9) == 0) begin
                    v.x = DEF_COORD_BITS'($urandom);
                    v.y = DEF_COORD_BITS'($urandom);
                end else begin
                    off_x = longint'($urandom_range(32'(2 * spread))) - spread;
                    off_y = longint'($urandom_range(32'(2 * spread))) - spread;
                    v.x = cx + DEF_COORD_BITS'(off_x);
                    v.y = cy + DEF_COORD_BITS'(off_y);
                end
                v.set_end = (c == n_cont - 1) && (k == n_vert - 1);
                v.contour_end = (k == n_vert - 1);
                // Set end with or without its own contour end; stray contour ends
                if (v.set_end) v.contour_end = 1'($urandom_range(1));
                else if ($urandom_range(19) == 0) v.contour_end = ~v.contour_end;
                send_vertex(v);
                random_items++;
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        vertex_ch.valid = 1'b0;
        vertex_ch.vertex_x = '0;
        vertex_ch.vertex_y = '0;
        vertex_ch.contour_end = 1'b0;
        vertex_ch.set_end = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Nine one-vertex contours at one corner, limit zero: every pair reported,
        // the ninth contour dropped. Hold ready off so the block backs up.
        write_limit('0);
        hold_rx = 1'b1;
        for (int k = 0; k < 9; k++) begin
            send_vertex(beat_of(24'h800000, 24'h7FFFFF, 1'b1, k == 8));
        end
        // Single contour closed by set end alone: not-found beat
        send_vertex(beat_of(24'h7FFFFF, 24'h800000, 1'b0, 1'b0));
        send_vertex(beat_of(24'h000000, 24'h000000, 1'b0, 1'b1));

        // Within the box but outside the circle, then exactly on it
        write_limit(23'd5);
        send_vertex(beat_of(24'd0, 24'd0, 1'b1, 1'b0));
        send_vertex(beat_of(24'd4, 24'd4, 1'b0, 1'b0));
        send_vertex(beat_of(24'd3, 24'd4, 1'b0, 1'b1));

        // Largest limit: widest gap that still counts, and ones just past it
        write_limit(23'h7FFFFF);
        send_vertex(beat_of(24'h800000, 24'd0, 1'b1, 1'b0));
        send_vertex(beat_of(24'hFFFFFF, 24'd0, 1'b1, 1'b0));
        send_vertex(beat_of(24'h7FFFFF, 24'd0, 1'b1, 1'b1));

        // Equal gaps on both loops: the later pair must win
        send_vertex(beat_of(24'd0, 24'd0, 1'b0, 1'b0));
        send_vertex(beat_of(24'd2, 24'd0, 1'b1, 1'b0));
        send_vertex(beat_of(24'd1, 24'd0, 1'b0, 1'b0));
        send_vertex(beat_of(24'd3, 24'd0, 1'b1, 1'b1));

        // Random sets; a stretch of them runs without any idling
        while (random_items < RANDOM_ITEMS) begin
            steady = (set_index >= 4 && set_index < 8);
            if (set_index == 0 || $urandom_range(1) == 1) begin
                case ($urandom_range(3))
                    0: write_limit(DIST_BITS'($urandom_range(4)));
                    1: write_limit(DIST_BITS'($urandom_range(2000)));
                    2: write_limit(DIST_BITS'($urandom));
                    default: write_limit($urandom_range(1) ? '1 : '0);
                endcase
            end
            random_set();
            set_index++;
        end
        steady = 1'b0;

        // Let every report arrive and the block settle
        vertex_ch.valid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Sent %0d vertices in %0d sets (%0d dropped for capacity).",
                 items_sent, sb.runs, sb.overflow_runs);
        $display("Checked %0d result beats, %0d of them close pairs, %0d mismatches.",
                 sb.checked, sb.close_pairs, sb.errors);
        if (sb.errors == 0) begin
            $display("** polygon_vertex_spacing_check: PASSED **");
        end else begin
            $display("** polygon_vertex_spacing_check: FAILED **");
        end
        $finish;
    end

endmodule
